### design/fat12_pkg.sv
// ----------------------------------------------------------------------------
// fat12_pkg
// Shared types and constants for the FAT12 table unpacker and chain walker.
// ----------------------------------------------------------------------------
package fat12_pkg;

  localparam int FAT_ENTRIES   = 4096;
  localparam int CLUSTER_BYTES = 512;
  localparam int MAX_CHUNKS    = 64;
  localparam int QUEUE_DEPTH   = 4;

  localparam int TABLE_BYTES   = (FAT_ENTRIES * 3 + 1) / 2;
  localparam int INDEX_W       = $clog2(FAT_ENTRIES);
  localparam int TRIPLE_W      = INDEX_W - 1;
  localparam int POS_W         = 13;
  localparam int ENTRY_W       = 12;
  localparam int SIZE_W        = 16;
  localparam int OFFSET_W      = 21;
  localparam int LENGTH_W      = 10;
  localparam int CLUSTER_SHIFT = $clog2(CLUSTER_BYTES);
  localparam int COUNT_W       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  // input kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_WALK = 1'b1;

  // queue command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_WALK  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [7:0]          fat_byte;
    logic [ENTRY_W-1:0]  start_cluster;
    logic [SIZE_W-1:0]   file_size;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] image_offset;
    logic [LENGTH_W-1:0] chunk_length;
    logic                last_chunk;
  } out_item_t;

  // Command passed from front to back: a table write or a walk request.
  typedef struct packed {
    logic                cmd;
    logic [ENTRY_W-1:0]  addr;   // entry index or start cluster
    logic [SIZE_W-1:0]   arg;    // entry value (low bits) or file size
  } cmd_t;

endpackage

### design/fat12_unpack_and_chain_walk_top.sv
// ----------------------------------------------------------------------------
// fat12_unpack_and_chain_walk_top
// FAT12 table unpacker and cluster chain walker, top level.
// ----------------------------------------------------------------------------
// Load transactions (kind 0) stream the packed FAT12 table in one byte at a
// time and are taken one per cycle while the command queue is not full;
// every second and third byte of a triple writes one 12-bit entry into a
// 4096-entry table RAM, and bytes past the table size are dropped. A walk
// transaction (kind 1) produces one chunk descriptor per cluster: offset
// cluster*512, length 512 or the remainder on the last cluster, and a last
// flag; a zero size yields one zero-length last chunk, and a walk stops
// after 64 chunks. For each chunk the walker first takes the walk off the
// queue or waits on the registered read of the table RAM for the next
// cluster number, then emits the chunk into the output register. A
// four-entry command queue sits between the input side and the walker, so
// loads and walks keep arriving while a walk is still emitting, and the
// output register holds a finished chunk while the sink stalls. Table
// entries must be loaded before a walk reads them; the table RAM has no
// reset. No configuration registers.
// ----------------------------------------------------------------------------
module fat12_unpack_and_chain_walk_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  fat12_pkg::in_item_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output fat12_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import fat12_pkg::*;

  // Front to queue: table writes and walk requests, in arrival order.
  logic q_push, q_full;
  cmd_t q_push_cmd;

  // Queue to back.
  logic q_pop, q_head_valid;
  cmd_t q_head_cmd;

  fat12_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd),
    .q_full   (q_full)
  );

  // Ordering through the queue keeps every entry write ahead of later walks.
  fat12_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  fat12_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_cmd     (q_head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

### design/fat12_ram.sv
// ----------------------------------------------------------------------------
// fat12_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fat12_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/fat12_queue.sv
// ----------------------------------------------------------------------------
// fat12_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module fat12_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fat12_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fat12_pkg::cmd_t head_cmd
);
  import fat12_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### design/fat12_front.sv
// ----------------------------------------------------------------------------
// fat12_front
// Input side: accept transactions, unpack FAT bytes into entry writes and
// forward walk requests to the command queue.
// ----------------------------------------------------------------------------
module fat12_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fat12_pkg::in_item_t in_data,
  output logic               in_stall,
  output logic               q_push,
  output fat12_pkg::cmd_t    q_cmd,
  input  logic               q_full
);
  import fat12_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [TRIPLE_W-1:0] triple_r, triple_nxt;
  logic [7:0]          first_r, first_nxt;
  logic [7:0]          second_r, second_nxt;
  logic                accept, table_full;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign table_full = (pos_r == POS_W'(TABLE_BYTES));

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    triple_nxt = triple_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    q_push     = 1'b0;
    q_cmd      = '0;
    if (accept && in_data.kind == KIND_WALK) begin
      q_push     = 1'b1;
      q_cmd.cmd  = CMD_WALK;
      q_cmd.addr = in_data.start_cluster;
      q_cmd.arg  = in_data.file_size;
    end else if (accept && !table_full) begin
      pos_nxt = pos_r + 1'b1;
      case (phase_r)
        PH_FIRST: begin
          first_nxt = in_data.fat_byte;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          second_nxt = in_data.fat_byte;
          phase_nxt  = PH_THIRD;
          q_push     = 1'b1;
          q_cmd.cmd  = CMD_WRITE;
          q_cmd.addr = ENTRY_W'({triple_r, 1'b0});
          q_cmd.arg  = SIZE_W'({in_data.fat_byte[3:0], first_r});
        end
        default: begin
          phase_nxt  = PH_FIRST;
          triple_nxt = triple_r + 1'b1;
          q_push     = 1'b1;
          q_cmd.cmd  = CMD_WRITE;
          q_cmd.addr = ENTRY_W'({triple_r, 1'b1});
          q_cmd.arg  = SIZE_W'({in_data.fat_byte, second_r[7:4]});
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= PH_FIRST;
      triple_r <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      triple_r <= triple_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

### design/fat12_back.sv
// ----------------------------------------------------------------------------
// fat12_back
// Execution side: apply table writes and walk cluster chains, one chunk
// descriptor per cluster, through a registered output stage.
// ----------------------------------------------------------------------------
module fat12_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fat12_pkg::cmd_t     q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output fat12_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import fat12_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [ENTRY_W-1:0] cluster_r, cluster_nxt;
  logic [SIZE_W-1:0]  remain_r, remain_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               out_free;
  logic               tbl_we;
  logic [ENTRY_W-1:0] tbl_rd_data;

  assign out_free = !out_valid_r || !out_stall;
  assign tbl_we   = (state_r == ST_IDLE) && q_valid && (q_cmd.cmd == CMD_WRITE);

  // Read port always follows the current cluster; data is ready in FETCH.
  fat12_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FAT_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (INDEX_W'(q_cmd.addr)),
    .wr_data (q_cmd.arg[ENTRY_W-1:0]),
    .rd_addr (INDEX_W'(cluster_r)),
    .rd_data (tbl_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cluster_nxt   = cluster_r;
    remain_nxt    = remain_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.cmd == CMD_WALK) begin
            cluster_nxt = q_cmd.addr;
            remain_nxt  = q_cmd.arg;
            count_nxt   = '0;
            state_nxt   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.image_offset = OFFSET_W'(cluster_r) << CLUSTER_SHIFT;
          if (remain_r <= SIZE_W'(CLUSTER_BYTES)) begin
            out_nxt.chunk_length = remain_r[LENGTH_W-1:0];
            out_nxt.last_chunk   = 1'b1;
            state_nxt            = ST_IDLE;
          end else begin
            out_nxt.chunk_length = LENGTH_W'(CLUSTER_BYTES);
            out_nxt.last_chunk   = (count_r == COUNT_W'(MAX_CHUNKS - 1));
            remain_nxt           = remain_r - SIZE_W'(CLUSTER_BYTES);
            count_nxt            = count_r + 1'b1;
            state_nxt            = (count_r == COUNT_W'(MAX_CHUNKS - 1)) ? ST_IDLE : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cluster_nxt = tbl_rd_data;
        state_nxt   = ST_EMIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cluster_r <= cluster_nxt;
    remain_r  <= remain_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/fat12_checker.sv
// ----------------------------------------------------------------------------
// fat12_checker
// Port-level assertions for the FAT12 chain walker, bound to the top level.
// ----------------------------------------------------------------------------
module fat12_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input fat12_pkg::out_item_t out_data,
  input logic                 out_stall
);
  import fat12_pkg::*;

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Drop any pending result on reset.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Queue is empty after reset, so input is open.
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // A short chunk only ends a file.
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.chunk_length != LENGTH_W'(CLUSTER_BYTES)) |->
      out_data.last_chunk)
    else $error("short chunk without last flag");

  // Offsets are cluster aligned.
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.image_offset[CLUSTER_SHIFT-1:0] == '0))
    else $error("unaligned image offset");

endmodule

bind fat12_unpack_and_chain_walk_top fat12_checker u_fat12_checker (.*);

### tb/tb_fat12_unpack_and_chain_walk_top.sv
// ----------------------------------------------------------------------------
// tb_fat12_unpack_and_chain_walk_top
// Self-checking bench for the FAT12 table unpacker and cluster chain walker.
// ----------------------------------------------------------------------------
// A short directed table covers reset, the field extremes, zero size, a chain
// through 0xfff, exact and overlong 64-chunk walks. A random part follows:
// table loads that mostly point back into the loaded region, mixed with
// walks whose size is cut so that no unloaded entry is ever read. Walks from
// anywhere in the cluster range then run, with a few stray loads in between.
// A mirror of the table predicts every chunk that is not typed in; results are
// checked in order, field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_fat12_unpack_and_chain_walk_top;
  import fat12_pkg::*;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int DRAIN_CYCLES = 2 * MAX_CHUNKS + 16;
  localparam int RANDOM_ITEMS = 240;
  localparam int RANDOM_WALKS = 200;

  // byte position inside a packed triple
  localparam int PH_LOW  = 0;
  localparam int PH_MID  = 1;
  localparam int PH_HIGH = 2;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  logic      out_stall = 1'b0;

  fat12_unpack_and_chain_walk_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table mirror and chunk prediction
  // --------------------------------------------------------------------------
  logic [ENTRY_W-1:0] fat_mirror [FAT_ENTRIES];
  bit                 entry_loaded [FAT_ENTRIES];
  logic [POS_W-1:0]   load_count = '0;
  logic [7:0]         triple_low = '0;
  logic [7:0]         triple_mid = '0;
  out_item_t          chunks_due [$];

  int cycle_cnt = 0;
  int errors    = 0;
  int accepted_cnt = 0;

  // Typed-in expectation that rides along with the current directed row.
  bit        cur_typed = 1'b0;
  out_item_t cur_typed_chunk = '0;

  // Apply one accepted transaction: unpack a byte, or walk a chain and
  // queue one chunk per cluster when record is set.
  task automatic unpack_or_walk(input in_item_t it, input bit record);
    int                 phase, pair, idx, left, n, offset_full, len_full;
    logic [ENTRY_W-1:0] cl, val;
    bit                 done;
    out_item_t          chunk;
    if (it.kind == KIND_LOAD) begin
      // drop bytes past the packed table size
      if (load_count < TABLE_BYTES) begin
        pair  = load_count / 3;
        phase = load_count % 3;
        if (phase == PH_LOW) begin
          triple_low = it.fat_byte;
        end else begin
          if (phase == PH_MID) begin
            triple_mid = it.fat_byte;
            idx = 2 * pair;
            val = {it.fat_byte[3:0], triple_low};
          end else begin
            idx = 2 * pair + 1;
            val = {it.fat_byte, triple_mid[7:4]};
          end
          fat_mirror[idx]   = val;
          entry_loaded[idx] = 1'b1;
        end
        load_count = load_count + 1'b1;
      end
    end else begin
      cl   = it.start_cluster;
      left = it.file_size;
      n    = 0;
      done = 1'b0;
      while (!done && n < MAX_CHUNKS) begin
        offset_full = cl * CLUSTER_BYTES;
        chunk.image_offset = offset_full[OFFSET_W-1:0];
        if (left <= CLUSTER_BYTES) begin
          chunk.chunk_length = left[LENGTH_W-1:0];
          chunk.last_chunk   = 1'b1;
          done = 1'b1;
        end else begin
          len_full = CLUSTER_BYTES;
          chunk.chunk_length = len_full[LENGTH_W-1:0];
          // a walk cut off at the chunk limit still flags its final chunk
          chunk.last_chunk   = (n + 1 == MAX_CHUNKS);
          left = left - CLUSTER_BYTES;
          // a 12-bit cluster always lies inside the 4096-entry table
          cl = fat_mirror[cl];
        end
        n++;
        if (record) chunks_due.push_back(chunk);
      end
    end
  endtask

  // Shorten a walk so that it never follows an entry that was not loaded.
  function automatic int cap_walk_size(input int start, input int size);
    int c, k, cap;
    c   = start;
    cap = size;
    for (k = 1; k <= MAX_CHUNKS && cap > k * CLUSTER_BYTES; k++) begin
      if (!entry_loaded[c]) cap = k * CLUSTER_BYTES;
      else c = fat_mirror[c];
    end
    return cap;
  endfunction

  // --------------------------------------------------------------------------
  // Acceptance and result checking, both sampled at the rising edge
  // --------------------------------------------------------------------------
  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_valid && !in_stall) begin
      // predict on acceptance; a typed row supplies its own expectation
      unpack_or_walk(in_data, !cur_typed);
      if (cur_typed) chunks_due.push_back(cur_typed_chunk);
      accepted_cnt++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (chunks_due.size() == 0) begin
        errors++;
        $display("%0t: chunk with none expected, actual offset %0d length %0d last %0d",
                 $time, out_data.image_offset, out_data.chunk_length,
                 out_data.last_chunk);
      end else begin
        want = chunks_due.pop_front();
        flag_field("image_offset", want.image_offset, out_data.image_offset);
        flag_field("chunk_length", want.chunk_length, out_data.chunk_length);
        flag_field("last_chunk",   want.last_chunk,   out_data.last_chunk);
      end
    end
  end

  // Hard stop in case the block hangs or drops chunks.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Idling on both sides
  // --------------------------------------------------------------------------
  // Mostly short gaps, a few long ones, and quiet stretches with none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (cycle_cnt % 2048 < 300) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  int stall_hold = 0;
  int stall_pick = 0;

  // Toggle the sink stall at the falling edge; hold each choice a while.
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else begin
      stall_pick = pick_gap();
      if (stall_pick == 0) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = stall_pick - 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  in_item_t  row_items [$];
  bit        row_typed [$];
  out_item_t row_chunk [$];

  function automatic in_item_t mk_load(input int b);
    in_item_t it;
    it.kind          = KIND_LOAD;
    it.fat_byte      = b[7:0];
    // the walk fields are don't-care here; fill them with noise
    it.start_cluster = $urandom_range(0, 4095);
    it.file_size     = $urandom_range(0, 65535);
    return it;
  endfunction

  function automatic in_item_t mk_walk(input int c, input int s);
    in_item_t it;
    it.kind          = KIND_WALK;
    it.fat_byte      = $urandom_range(0, 255);
    it.start_cluster = c[ENTRY_W-1:0];
    it.file_size     = s[SIZE_W-1:0];
    return it;
  endfunction

  function automatic out_item_t mk_chunk(input int off, input int len, input bit last);
    out_item_t ch;
    ch.image_offset = off[OFFSET_W-1:0];
    ch.chunk_length = len[LENGTH_W-1:0];
    ch.last_chunk   = last;
    return ch;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t ch);
    row_items.push_back(it);
    row_typed.push_back(typed);
    row_chunk.push_back(ch);
  endfunction

  // Mostly sizes that give short or medium walks, plus zero, cluster
  // boundaries and sizes past the 64-chunk limit.
  function automatic int pick_file_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 20) return $urandom_range(1, CLUSTER_BYTES);
    if (r < 35) return $urandom_range(1, MAX_CHUNKS) * CLUSTER_BYTES + $urandom_range(0, 2) - 1;
    if (r < 45) return $urandom_range(32768, 65535);
    if (r < 70) return $urandom_range(CLUSTER_BYTES + 1, 8 * CLUSTER_BYTES);
    return $urandom_range(0, MAX_CHUNKS * CLUSTER_BYTES);
  endfunction

  // Entry value for entry e: mostly a link back into the loaded region.
  function automatic int pick_link(input int e);
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, e);
    return $urandom_range(0, 4095);
  endfunction

  // Drive one transaction at the falling edge; hold it until accepted.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t ch);
    int gap, seen;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data         = it;
    cur_typed       = typed;
    cur_typed_chunk = ch;
    in_valid        = 1'b1;
    seen            = accepted_cnt;
    do @(negedge clk); while (accepted_cnt == seen);
  endtask

  // Pack two 12-bit entries into one triple of load transactions.
  task automatic send_pair(input int v0, input int v1);
    logic [11:0] e0, e1;
    e0 = v0[11:0];
    e1 = v1[11:0];
    send_item(mk_load(e0[7:0]), 1'b0, '0);
    send_item(mk_load({e1[3:0], e0[11:8]}), 1'b0, '0);
    send_item(mk_load(e1[11:4]), 1'b0, '0);
  endtask

  initial begin
    int i, c, e, sent, walks;

    // Walks that read no entry: expected chunk typed in.
    add_row(mk_walk(0, 0),       1'b1, mk_chunk(0, 0, 1'b1));
    add_row(mk_walk(4095, 512),  1'b1, mk_chunk(2096640, 512, 1'b1));
    add_row(mk_walk(4095, 1),    1'b1, mk_chunk(2096640, 1, 1'b1));
    add_row(mk_walk(2048, 511),  1'b1, mk_chunk(1048576, 511, 1'b1));
    // Entries 0..5 = 001, 002, 003, fff, 000, 005 (5 links to itself).
    add_row(mk_load(8'h01), 1'b0, '0);
    add_row(mk_load(8'h20), 1'b0, '0);
    add_row(mk_load(8'h00), 1'b0, '0);
    add_row(mk_load(8'h03), 1'b0, '0);
    add_row(mk_load(8'hf0), 1'b0, '0);
    add_row(mk_load(8'hff), 1'b0, '0);
    add_row(mk_load(8'h00), 1'b0, '0);
    add_row(mk_load(8'h50), 1'b0, '0);
    add_row(mk_load(8'h00), 1'b0, '0);
    add_row(mk_walk(0, 2048),    1'b0, '0);   // four full clusters
    add_row(mk_walk(0, 2560),    1'b0, '0);   // last chunk lands on 0xfff
    add_row(mk_walk(4, 1000),    1'b0, '0);   // wrap back to cluster 0
    add_row(mk_walk(5, 65535),   1'b0, '0);   // cut off at the chunk limit
    add_row(mk_walk(5, 32768),   1'b0, '0);   // exactly 64 full chunks
    add_row(mk_walk(5, 32769),   1'b0, '0);   // one byte past the limit
    add_row(mk_walk(2, 513),     1'b0, '0);
    add_row(mk_walk(3, 512),     1'b1, mk_chunk(1536, 512, 1'b1));

    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < row_items.size(); i++)
      send_item(row_items[i], row_typed[i], row_chunk[i]);

    // Grow the table with links into its loaded part, walk in between.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      e = (load_count / 3) * 2;
      if ($urandom_range(0, 1) == 0) begin
        send_pair(pick_link(e), pick_link(e + 1));
        sent += 3;
      end else begin
        c = (e > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, e - 1)
                                                 : $urandom_range(0, 4095);
        send_item(mk_walk(c, cap_walk_size(c, pick_file_size())), 1'b0, '0);
        sent++;
      end
    end

    // Walk from anywhere in the cluster range, with a few stray loads.
    walks = 0;
    while (walks < RANDOM_WALKS) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(mk_load($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        c = $urandom_range(0, 4095);
        send_item(mk_walk(c, cap_walk_size(c, pick_file_size())), 1'b0, '0);
        walks++;
      end
    end

    // Drain, then give the block time to show any stray chunk.
    in_valid = 1'b0;
    while (chunks_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
design/fat12_pkg.sv
design/fat12_ram.sv
design/fat12_queue.sv
design/fat12_front.sv
design/fat12_back.sv
design/fat12_unpack_and_chain_walk_top.sv
design/fat12_checker.sv
tb/tb_fat12_unpack_and_chain_walk_top.sv
